// ===== sv/csl_pkg.sv =====
// shared types and constants for the character stream lexer
`default_nettype none

package csl_pkg;

    // position field widths and saturation limits
    localparam int LINE_W = 16;
    localparam int COL_W  = 12;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [COL_W-1:0]  COL_MAX  = '1;

    // token kinds
    localparam logic [5:0] K_IDENT  = 6'd12;
    localparam logic [5:0] K_INT    = 6'd13;
    localparam logic [5:0] K_FLOAT  = 6'd14;
    localparam logic [5:0] K_STRING = 6'd15;
    localparam logic [5:0] K_COMMA  = 6'd16;
    localparam logic [5:0] K_PLUS   = 6'd17;
    localparam logic [5:0] K_MINUS  = 6'd18;
    localparam logic [5:0] K_TIMES  = 6'd19;
    localparam logic [5:0] K_DIVIDE = 6'd20;
    localparam logic [5:0] K_REM    = 6'd21;
    localparam logic [5:0] K_ASSIGN = 6'd22;
    localparam logic [5:0] K_EQ     = 6'd23;
    localparam logic [5:0] K_LPAREN = 6'd24;
    localparam logic [5:0] K_RPAREN = 6'd25;
    localparam logic [5:0] K_LT     = 6'd26;
    localparam logic [5:0] K_LE     = 6'd27;
    localparam logic [5:0] K_GT     = 6'd28;
    localparam logic [5:0] K_GE     = 6'd29;
    localparam logic [5:0] K_NE     = 6'd30;
    localparam logic [5:0] K_EOF    = 6'd31;
    localparam logic [5:0] K_ERROR  = 6'd32;

    // keyword spellings, first character in the low byte, zero padded
    localparam int KW_COUNT = 12;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("tes"), 64'("tnirp"), 64'("elihw"), 64'("od"), 64'("dne"), 64'("dna"),
        64'("ro"), 64'("fi"), 64'("neht"), 64'("esle"), 64'("fidne"), 64'("margorp")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd5, 4'd5, 4'd2, 4'd3, 4'd3, 4'd2, 4'd2, 4'd4, 4'd4, 4'd5, 4'd7
    };

    // output queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_COMMENT = 4'd1,
        MODE_WORD    = 4'd2,
        MODE_INT     = 4'd3,
        MODE_FRAC    = 4'd4,
        MODE_STRING  = 4'd5,
        MODE_EQ      = 4'd6,
        MODE_LT      = 4'd7,
        MODE_GT      = 4'd8,
        MODE_BANG    = 4'd9
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [5:0]        kind;
        logic [LINE_W-1:0] start_line;
        logic [COL_W-1:0]  start_column;
        logic [7:0]        token_length;
        logic              last_of_run;
    } t_out_item;

    // results produced by one accepted item
    typedef struct packed {
        logic [1:0] count;
        t_out_item  item0;
        t_out_item  item1;
    } t_emit;

endpackage

`default_nettype wire

// ===== sv/character_stream_lexer.sv =====
// character stream lexer top level
//
// Input channel: one source byte per item (i_in_item.ch), or an end marker
// (i_in_item.end_of_input). Output channel: one token per item with kind,
// start line, start column, length and a flag on the last token that a
// given input item caused. Both sides use valid / stall.
//
// Each accepted byte is classified in the same cycle it is taken; the
// tokens it closes are written to a four-entry result queue and are
// offered on the output from the next cycle on.
// One byte per cycle is taken while the queue has room for two tokens;
// a byte that closes two tokens fills the queue faster than it drains,
// so a long run of such bytes is held back by o_in_stall.
// When the receiver stalls, the queue fills and o_in_stall rises once
// three tokens wait; nothing is dropped.
// After end of input or a '$' every further byte is taken and ignored.
// Reset clears the scanner state, the position counters and the queue;
// no clearing pass is needed.
`default_nettype none

module character_stream_lexer import csl_pkg::*; #(
    parameter int KEYWORD_CHARS    = 7,
    parameter int MAX_TOKEN_LENGTH = 255
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    t_emit emit;
    logic  accept;

    assign accept = i_in_valid && !o_in_stall;

    csl_core #(
        .KEYWORD_CHARS    (KEYWORD_CHARS),
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_emit   (emit)
    );

    csl_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (emit),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_full      (o_in_stall)
    );

endmodule

`default_nettype wire

// ===== sv/csl_core.sv =====
// scanner state and per-character token decisions
`default_nettype none

module csl_core import csl_pkg::*; #(
    parameter int KEYWORD_CHARS    = 7,
    parameter int MAX_TOKEN_LENGTH = 255
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output t_emit         o_emit
);

    localparam int PW = 8 * KEYWORD_CHARS;
    localparam int LW = $clog2(MAX_TOKEN_LENGTH + 1);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_GT    = 8'h3e;

    t_mode             r_mode, n_mode;
    logic [PW-1:0]     r_prefix, n_prefix;
    logic [LW-1:0]     r_plen, n_plen;
    logic [LINE_W-1:0] r_pline, n_pline, r_cline, n_cline;
    logic [COL_W-1:0]  r_pcol, n_pcol, r_ccol, n_ccol;
    logic              r_fin, n_fin;

    logic [7:0] ch;
    logic       act, eoi;
    logic       is_alpha, is_digit, is_nl;

    // saturate the pending count to the output field
    function automatic logic [7:0] sat_len(input logic [LW-1:0] v);
        if (32'(v) > 255) begin
            return 8'hff;
        end
        return 8'(v);
    endfunction

    function automatic t_out_item mk(input logic [5:0] kind, input logic [LINE_W-1:0] line,
                                     input logic [COL_W-1:0] col, input logic [7:0] len);
        t_out_item it;
        it.kind         = kind;
        it.start_line   = line;
        it.start_column = col;
        it.token_length = len;
        it.last_of_run  = 1'b0;
        return it;
    endfunction

    assign ch       = i_item.ch;
    assign eoi      = i_item.end_of_input;
    assign act      = i_accept && !r_fin;
    assign is_alpha = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
    assign is_digit = ch >= 8'h30 && ch <= 8'h39;
    assign is_nl    = ch == CH_NL;

    // what a fresh character starts
    logic       st_begin, st_single, st_comment, st_dollar;
    t_mode      st_mode;
    logic [5:0] st_kind;

    always_comb begin
        st_begin   = 1'b0;
        st_single  = 1'b0;
        st_comment = 1'b0;
        st_dollar  = 1'b0;
        st_mode    = MODE_IDLE;
        st_kind    = K_ERROR;
        priority if (ch == CH_SPACE || ch == CH_TAB || is_nl) begin
            st_mode = MODE_IDLE;
        end else if (ch == CH_HASH) begin
            st_comment = 1'b1;
        end else if (is_alpha) begin
            st_begin = 1'b1;
            st_mode  = MODE_WORD;
        end else if (is_digit) begin
            st_begin = 1'b1;
            st_mode  = MODE_INT;
        end else begin
            unique case (ch)
                CH_QUOTE: begin st_begin = 1'b1; st_mode = MODE_STRING; end
                CH_EQ:    begin st_begin = 1'b1; st_mode = MODE_EQ;     end
                CH_LT:    begin st_begin = 1'b1; st_mode = MODE_LT;     end
                CH_GT:    begin st_begin = 1'b1; st_mode = MODE_GT;     end
                CH_BANG:  begin st_begin = 1'b1; st_mode = MODE_BANG;   end
                CH_COMMA: begin st_single = 1'b1; st_kind = K_COMMA;  end
                CH_PLUS:  begin st_single = 1'b1; st_kind = K_PLUS;   end
                CH_MINUS: begin st_single = 1'b1; st_kind = K_MINUS;  end
                CH_STAR:  begin st_single = 1'b1; st_kind = K_TIMES;  end
                CH_SLASH: begin st_single = 1'b1; st_kind = K_DIVIDE; end
                CH_PCT:   begin st_single = 1'b1; st_kind = K_REM;    end
                CH_LPAR:  begin st_single = 1'b1; st_kind = K_LPAREN; end
                CH_RPAR:  begin st_single = 1'b1; st_kind = K_RPAREN; end
                CH_DOLL:  begin
                    st_single = 1'b1;
                    st_kind   = K_EOF;
                    st_dollar = 1'b1;
                end
                default:  begin st_single = 1'b1; st_kind = K_ERROR;  end
            endcase
        end
    end

    // kind of the pending token if it is closed now
    logic       pend_any;
    logic [5:0] pend_kind, word_kind, pair_kind;

    always_comb begin
        word_kind = K_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (32'(r_plen) == 32'(KW_LEN[k]) && r_prefix == KW_TEXT[k][PW-1:0]) begin
                word_kind = 6'(k);
            end
        end
        pend_any  = 1'b1;
        pend_kind = K_ERROR;
        pair_kind = K_NE;
        unique case (r_mode)
            MODE_WORD:   pend_kind = word_kind;
            MODE_INT:    pend_kind = K_INT;
            MODE_FRAC:   pend_kind = K_FLOAT;
            MODE_STRING: pend_kind = K_ERROR;
            MODE_EQ:     begin pend_kind = K_ASSIGN; pair_kind = K_EQ; end
            MODE_LT:     begin pend_kind = K_LT;     pair_kind = K_LE; end
            MODE_GT:     begin pend_kind = K_GT;     pair_kind = K_GE; end
            MODE_BANG:   pend_kind = K_ERROR;
            default:     pend_any = 1'b0;
        endcase
    end

    // per-mode decision for a non-terminating character
    logic keep_add, to_frac, close_str, do_pair, comment_end, restart, do_flush;

    always_comb begin
        keep_add    = 1'b0;
        to_frac     = 1'b0;
        close_str   = 1'b0;
        do_pair     = 1'b0;
        comment_end = 1'b0;
        restart     = 1'b0;
        unique case (r_mode)
            MODE_COMMENT: comment_end = is_nl;
            MODE_WORD: begin
                keep_add = is_alpha || is_digit;
                restart  = !(is_alpha || is_digit);
            end
            MODE_INT: begin
                keep_add = is_digit || ch == CH_DOT;
                to_frac  = ch == CH_DOT;
                restart  = !(is_digit || ch == CH_DOT);
            end
            MODE_FRAC: begin
                keep_add = is_digit;
                restart  = !is_digit;
            end
            MODE_STRING: begin
                close_str = ch == CH_QUOTE;
                keep_add  = ch != CH_QUOTE;
            end
            MODE_EQ, MODE_LT, MODE_GT, MODE_BANG: begin
                do_pair = ch == CH_EQ;
                restart = ch != CH_EQ;
            end
            default: restart = 1'b1;
        endcase
        do_flush = restart && pend_any;
    end

    // results for this item
    t_out_item pend_item, single_item, eof_item;

    always_comb begin
        pend_item   = mk(pend_kind, r_pline, r_pcol, sat_len(r_plen));
        single_item = mk(st_kind, r_cline, r_ccol, 8'd1);
        eof_item    = mk(K_EOF, r_cline, r_ccol, 8'd0);
        o_emit      = '0;
        if (act) begin
            if (eoi) begin
                if (pend_any) begin
                    o_emit.item0 = pend_item;
                    o_emit.item1 = eof_item;
                    o_emit.count = 2'd2;
                end else begin
                    o_emit.item0 = eof_item;
                    o_emit.count = 2'd1;
                end
            end else if (close_str) begin
                o_emit.item0 = mk(K_STRING, r_pline, r_pcol, sat_len(r_plen));
                o_emit.count = 2'd1;
            end else if (do_pair) begin
                o_emit.item0 = mk(pair_kind, r_pline, r_pcol, 8'd2);
                o_emit.count = 2'd1;
            end else if (restart) begin
                if (do_flush) begin
                    o_emit.item0 = pend_item;
                    o_emit.item1 = single_item;
                    o_emit.count = st_single ? 2'd2 : 2'd1;
                end else if (st_single) begin
                    o_emit.item0 = single_item;
                    o_emit.count = 2'd1;
                end
            end
        end
        // mark the final result of the item
        if (o_emit.count == 2'd2) begin
            o_emit.item1.last_of_run = 1'b1;
        end else if (o_emit.count == 2'd1) begin
            o_emit.item0.last_of_run = 1'b1;
        end
    end

    // next scanner state
    always_comb begin
        n_mode   = r_mode;
        n_prefix = r_prefix;
        n_plen   = r_plen;
        n_pline  = r_pline;
        n_pcol   = r_pcol;
        n_cline  = r_cline;
        n_ccol   = r_ccol;
        n_fin    = r_fin;
        if (act) begin
            if (eoi) begin
                n_mode   = MODE_IDLE;
                n_prefix = '0;
                n_plen   = '0;
                n_fin    = 1'b1;
            end else begin
                if (comment_end) begin
                    n_mode = MODE_IDLE;
                end
                if (keep_add) begin
                    for (int i = 0; i < KEYWORD_CHARS; i++) begin
                        if (32'(r_plen) == i) begin
                            n_prefix[8*i +: 8] = ch;
                        end
                    end
                    if (32'(r_plen) < MAX_TOKEN_LENGTH) begin
                        n_plen = r_plen + 1'b1;
                    end
                    if (to_frac) begin
                        n_mode = MODE_FRAC;
                    end
                end
                if (close_str) begin
                    n_mode = MODE_IDLE;
                    n_plen = '0;
                end
                if (do_pair) begin
                    n_mode   = MODE_IDLE;
                    n_plen   = '0;
                    n_prefix = '0;
                end
                if (restart) begin
                    n_mode   = st_comment ? MODE_COMMENT : MODE_IDLE;
                    n_prefix = '0;
                    n_plen   = '0;
                    if (st_begin) begin
                        n_mode  = st_mode;
                        n_pline = r_cline;
                        n_pcol  = r_ccol;
                        if (st_mode != MODE_STRING) begin
                            n_prefix[7:0] = ch;
                            n_plen        = LW'(1);
                        end
                    end
                    if (st_dollar) begin
                        n_fin = 1'b1;
                    end
                end
                // position tracking, saturating
                if (is_nl) begin
                    if (r_cline != LINE_MAX) begin
                        n_cline = r_cline + 1'b1;
                    end
                    n_ccol = '0;
                end else if (r_ccol != COL_MAX) begin
                    n_ccol = r_ccol + 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_prefix <= '0;
            r_plen   <= '0;
            r_pline  <= '0;
            r_pcol   <= '0;
            r_cline  <= '0;
            r_ccol   <= '0;
            r_fin    <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_prefix <= n_prefix;
            r_plen   <= n_plen;
            r_pline  <= n_pline;
            r_pcol   <= n_pcol;
            r_cline  <= n_cline;
            r_ccol   <= n_ccol;
            r_fin    <= n_fin;
        end
    end

endmodule

`default_nettype wire

// ===== sv/csl_out_fifo.sv =====
// four-entry result queue taking up to two items per cycle
`default_nettype none

module csl_out_fifo import csl_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_emit i_push,
    input  wire logic  i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_item,
    output logic       o_full
);

    t_out_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]     r_head, n_head, r_tail, n_tail;
    logic [Q_AW:0]       r_count, n_count;
    logic                pop;

    assign o_out_valid = r_count != '0;
    assign o_out_item  = r_mem[r_head];
    assign pop         = o_out_valid && !i_out_stall;
    // room for two results is kept for the next item
    assign o_full      = 32'(r_count) > Q_DEPTH - 2;

    // pointer and fill bookkeeping
    always_comb begin
        n_head  = pop ? r_head + 1'b1 : r_head;
        n_tail  = r_tail + Q_AW'(i_push.count);
        n_count = r_count + (Q_AW+1)'(i_push.count) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // entry writes
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.item0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_tail + 1'b1] <= i_push.item1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/csl_checker.sv =====
// port-level checks for the character stream lexer and their binding
`default_nettype none

module csl_checker import csl_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // a stalled input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input item changed");

    // a stalled token holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled token changed");

    // after eof is delivered the output goes idle
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_item.kind == K_EOF |=> !o_out_valid)
        else $error("token after eof");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("token offered after reset");

    // two-character operators always report length two
    a_pair_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == K_EQ || o_out_item.kind == K_LE ||
                        o_out_item.kind == K_GE || o_out_item.kind == K_NE)
        |-> o_out_item.token_length == 8'd2)
        else $error("bad two-character operator length");

endmodule

bind character_stream_lexer csl_checker u_csl_checker (.*);

`default_nettype wire
